>>> hdl/ctsd_pkg.sv
// Shared types and constants for the color template screen detector.
// Used by ctsd_dist, ctsd_decide and color_template_screen_detect.
`timescale 1ns / 1ps

package ctsd_pkg;

    localparam int CHAN_W            = 8;
    localparam int SUM_W             = 16;
    localparam int SQ_W              = 18;
    localparam int FRACTION_BITS_DEF = 4;

    localparam logic [SUM_W-1:0] SUM_MAX     = 16'hFFFF;
    localparam logic [SUM_W-1:0] LIMIT_RESET = 16'd1836;

    localparam logic KIND_PRIMARY   = 1'b0;
    localparam logic KIND_SECONDARY = 1'b1;

    // Register select, taken from paddr[2].
    localparam logic REG_PRIMARY_LIMIT   = 1'b0;
    localparam logic REG_SECONDARY_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        DIST_IDLE,
        DIST_SQUARE,
        DIST_ROOT,
        DIST_DONE
    } dist_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_CALC
    } top_state_t;

    typedef struct packed {
        logic update;
        logic kind;
        logic last;
    } ctsd_ctrl_t;

    typedef struct packed {
        logic             set_done;
        logic             is_match;
        logic             new_screen;
        logic [SUM_W-1:0] distance_sum;
    } ctsd_result_t;

endpackage

>>> hdl/ctsd_dist.sv
// Serial RGB distance unit: squares one channel difference per cycle, then
// takes the square root one result bit per cycle. Depends on ctsd_pkg.
`timescale 1ns / 1ps

module ctsd_dist
    import ctsd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int ROOT_W        = (SQ_W + 2 * FRACTION_BITS + 1) / 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [3*CHAN_W-1:0]   observed,
    input  logic [3*CHAN_W-1:0]   expected,
    output logic                  done,
    output logic [ROOT_W-1:0]     distance
);

    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

    dist_state_t state_reg, state_next;

    logic [3*CHAN_W-1:0] obs_reg, obs_next;
    logic [3*CHAN_W-1:0] exp_reg, exp_next;
    logic [SQ_W-1:0]     acc_reg, acc_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;

    logic [CHAN_W-1:0]   diff;
    logic [2*CHAN_W-1:0] sq;
    logic [SQ_W-1:0]     acc_sum;
    logic [REM_W+1:0]    rem_shift;
    logic [REM_W+1:0]    trial;
    logic                fits;
    logic                last_square;
    logic                last_step;

    assign diff = (obs_reg[CHAN_W-1:0] >= exp_reg[CHAN_W-1:0])
                ? obs_reg[CHAN_W-1:0] - exp_reg[CHAN_W-1:0]
                : exp_reg[CHAN_W-1:0] - obs_reg[CHAN_W-1:0];
    assign sq      = {{CHAN_W{1'b0}}, diff} * {{CHAN_W{1'b0}}, diff};
    assign acc_sum = acc_reg + SQ_W'(sq);

    // Two radicand bits enter the remainder each step.
    assign rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    assign last_square = (cnt_reg == 2'd2);
    assign last_step   = (step_reg == STEP_W'(ROOT_W - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIST_IDLE, DIST_DONE:
            begin
                if (start)
                    state_next = DIST_SQUARE;
            end
            DIST_SQUARE:
            begin
                if (last_square)
                    state_next = DIST_ROOT;
            end
            DIST_ROOT:
            begin
                if (last_step)
                    state_next = DIST_DONE;
            end
            default:
                state_next = DIST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        done = 1'b0;
        case (state_reg)
            DIST_DONE: done = 1'b1;
            default:   done = 1'b0;
        endcase
    end

    assign distance = root_reg;

    // Datapath
    always_comb
    begin
        obs_next  = obs_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start && (state_reg == DIST_IDLE || state_reg == DIST_DONE))
        begin
            obs_next = observed;
            exp_next = expected;
            acc_next = '0;
            cnt_next = 2'd0;
        end
        else if (state_reg == DIST_SQUARE)
        begin
            obs_next = obs_reg >> CHAN_W;
            exp_next = exp_reg >> CHAN_W;
            acc_next = acc_sum;
            cnt_next = cnt_reg + 2'd1;
            if (last_square)
            begin
                rad_next  = RAD_W'(acc_sum) << (2 * FRACTION_BITS);
                rem_next  = '0;
                root_next = '0;
                step_next = '0;
            end
        end
        else if (state_reg == DIST_ROOT)
        begin
            rad_next  = rad_reg << 2;
            step_next = step_reg + STEP_W'(1);
            if (fits)
            begin
                rem_next  = REM_W'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIST_IDLE;
            cnt_reg   <= 2'd0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obs_reg  <= obs_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

>>> hdl/ctsd_decide.sv
// Per-set accumulators, limit compare and match history.
// Depends on ctsd_pkg.
`timescale 1ns / 1ps

module ctsd_decide
    import ctsd_pkg::*;
#(
    parameter int ROOT_W = (SQ_W + 2 * FRACTION_BITS_DEF + 1) / 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctsd_ctrl_t        ctrl,
    input  logic [ROOT_W-1:0] distance,
    input  logic [SUM_W-1:0]  primary_limit,
    input  logic [SUM_W-1:0]  secondary_limit,
    output ctsd_result_t      result
);

    localparam int SUMT_W = ((ROOT_W > SUM_W) ? ROOT_W : SUM_W) + 1;

    logic [SUM_W-1:0] psum_reg, psum_next;
    logic [SUM_W-1:0] ssum_reg, ssum_next;
    logic             pnow_reg, pnow_next;
    logic             pwas_reg, pwas_next;
    logic             swas_reg, swas_next;

    logic [SUM_W-1:0]  sum_sel;
    logic [SUMT_W-1:0] sum_wide;
    logic [SUM_W-1:0]  sum_new;
    logic              below;
    logic              match;
    logic              fresh;

    assign sum_sel  = (ctrl.kind == KIND_SECONDARY) ? ssum_reg : psum_reg;
    assign sum_wide = SUMT_W'(sum_sel) + SUMT_W'(distance);
    assign sum_new  = (sum_wide > SUMT_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb
    begin
        if (ctrl.kind == KIND_SECONDARY)
        begin
            below = (sum_new <= secondary_limit);
            match = below && !pnow_reg;
            fresh = match && !swas_reg;
        end
        else
        begin
            below = (sum_new <= primary_limit);
            match = below;
            fresh = match && !pwas_reg;
        end
    end

    assign result.set_done     = ctrl.kind;
    assign result.is_match     = match;
    assign result.new_screen   = fresh;
    assign result.distance_sum = sum_new;

    always_comb
    begin
        psum_next = psum_reg;
        ssum_next = ssum_reg;
        pnow_next = pnow_reg;
        pwas_next = pwas_reg;
        swas_next = swas_reg;
        if (ctrl.update)
        begin
            if (ctrl.kind == KIND_SECONDARY)
            begin
                ssum_next = ctrl.last ? '0 : sum_new;
                if (ctrl.last)
                    swas_next = match;
            end
            else
            begin
                psum_next = ctrl.last ? '0 : sum_new;
                if (ctrl.last)
                begin
                    pnow_next = match;
                    pwas_next = match;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= '0;
            ssum_reg <= '0;
            pnow_reg <= 1'b0;
            pwas_reg <= 1'b0;
            swas_reg <= 1'b0;
        end
        else
        begin
            psum_reg <= psum_next;
            ssum_reg <= ssum_next;
            pnow_reg <= pnow_next;
            pwas_reg <= pwas_next;
            swas_reg <= swas_next;
        end
    end

endmodule

>>> hdl/color_template_screen_detect.sv
// Top level of the color template screen detector: stream ports, APB limit
// registers, control and output register. Uses ctsd_pkg, ctsd_dist, ctsd_decide.
`timescale 1ns / 1ps

// Each input request on the s_ stream carries one test point: observed and
// reference RGB in s_tdata, the set (primary or secondary) in s_tuser and the
// final sample of the set in s_tlast. A sample that is not last produces no
// output; the last sample of a set produces one request on the m_ stream with
// the set in m_tuser and match, new-screen flag and distance sum in m_tdata.
// Each sample has its channel differences squared and summed, then goes through
// the bit-serial square root (ROOT_W = (18 + 2*FRACTION_BITS + 1)/2,
// 13 for FRACTION_BITS 4), then updates the sums. A new sample is accepted
// only after the previous one has updated the sums; the square root takes the
// largest share of each sample.
// The result sits in an output register, so a stalled receiver does not block
// the next sample; only a second result waiting for that register holds the
// block. Reset clears sums and match history and loads both limits with 1836.
// Limits are written over APB at 0x0 (primary) and 0x4 (secondary).

module color_template_screen_detect
    import ctsd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Sample stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // observed_red, observed_green, observed_blue, ref_red, ref_green, ref_blue
    input  logic [47:0]         s_tdata,
    input  logic                s_tlast,
    // kind
    input  logic                s_tuser,
    // Decision stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // is_match, new_screen, distance_sum[15:0], zero padding
    output logic [23:0]         m_tdata,
    // set_done
    output logic                m_tuser
);

    localparam int ROOT_W = (SQ_W + 2 * FRACTION_BITS + 1) / 2;

    top_state_t state_reg, state_next;

    logic [SUM_W-1:0] plimit_reg, plimit_next;
    logic [SUM_W-1:0] slimit_reg, slimit_next;
    logic             kind_reg, kind_next;
    logic             last_reg, last_next;
    logic             mvalid_reg, mvalid_next;
    ctsd_result_t     mres_reg, mres_next;

    logic              cfg_write;
    logic              accept;
    logic              dist_done;
    logic [ROOT_W-1:0] distance;
    logic              out_free;
    logic              commit;
    ctsd_ctrl_t        ctrl;
    ctsd_result_t      result;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SECONDARY_LIMIT) ? {16'd0, slimit_reg}
                                                         : {16'd0, plimit_reg};

    always_comb
    begin
        plimit_next = plimit_reg;
        slimit_next = slimit_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_PRIMARY_LIMIT:   plimit_next = pwdata[SUM_W-1:0];
                REG_SECONDARY_LIMIT: slimit_next = pwdata[SUM_W-1:0];
                default:             plimit_next = plimit_reg;
            endcase
        end
    end

    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:
            begin
                if (accept)
                    state_next = TOP_CALC;
            end
            TOP_CALC:
            begin
                if (dist_done && (!last_reg || out_free))
                    state_next = TOP_IDLE;
            end
            default:
                state_next = TOP_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            TOP_IDLE: s_tready = 1'b1;
            TOP_CALC: commit   = dist_done && (!last_reg || out_free);
            default:  s_tready = 1'b0;
        endcase
    end

    assign kind_next = accept ? s_tuser : kind_reg;
    assign last_next = accept ? s_tlast : last_reg;

    assign ctrl.update = commit;
    assign ctrl.kind   = kind_reg;
    assign ctrl.last   = last_reg;

    ctsd_dist #(
        .FRACTION_BITS (FRACTION_BITS),
        .ROOT_W        (ROOT_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .observed (s_tdata[23:0]),
        .expected (s_tdata[47:24]),
        .done     (dist_done),
        .distance (distance)
    );

    ctsd_decide #(
        .ROOT_W (ROOT_W)
    ) u_decide (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .distance        (distance),
        .primary_limit   (plimit_reg),
        .secondary_limit (slimit_reg),
        .result          (result)
    );

    // Output register
    always_comb
    begin
        mvalid_next = mvalid_reg;
        mres_next   = mres_reg;
        if (commit && last_reg)
        begin
            mvalid_next = 1'b1;
            mres_next   = result;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mres_reg.set_done;
    assign m_tdata  = {6'd0, mres_reg.distance_sum, mres_reg.new_screen, mres_reg.is_match};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= TOP_IDLE;
            plimit_reg <= LIMIT_RESET;
            slimit_reg <= LIMIT_RESET;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            plimit_reg <= plimit_next;
            slimit_reg <= slimit_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        last_reg <= last_next;
        mres_reg <= mres_next;
    end

    // A closing sample always leaves a result in the output register.
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && last_reg) |=> m_tvalid)
        else $error("closing sample did not load the output register");

    // An accepted sample restarts the distance unit.
    a_accept_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!dist_done && !s_tready))
        else $error("distance unit not restarted on accepted sample");

    // A result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !(commit && last_reg))
        else $error("pending result overwritten");

endmodule
